// ===== src/mau_pkg.sv =====
package mau_pkg;

  // Operation selector carried in the slave tuser
  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  // Control of one modular double-and-add step
  typedef struct packed {
    logic dbl;
    logic add;
  } step_ctl_t;

endpackage

// ===== src/mau_step.sv =====
// One modular step: ((dbl ? 2*acc : acc) + (add ? addend : 0)) mod m.
// Inputs acc and addend must lie below m.
module mau_step import mau_pkg::*; #(
  parameter int W = 63
) (
  input  logic [W-1:0] acc,
  input  logic [W-1:0] addend,
  input  logic [W-1:0] m,
  input  step_ctl_t    ctl,
  output logic [W-1:0] sum
);

  logic [W:0] d;
  logic [W:0] d1;
  logic [W:0] s;

  // Double and reduce, then add and reduce
  always_comb begin
    d  = ctl.dbl ? {acc, 1'b0} : {1'b0, acc};
    d1 = (d >= {1'b0, m}) ? (d - {1'b0, m}) : d;
    s  = d1 + (ctl.add ? {1'b0, addend} : '0);
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    sum = s[W-1:0];
  end

endmodule

// ===== src/modular_arithmetic_unit.sv =====
// Sequence: the operands are reduced mod m one bit at a time, then add or subtract
// completes directly and multiply runs a double-and-add loop over the multiplier bits.
// Divide runs extended Euclid steps (align the divisor, then shift-subtract over the
// remainders' bit-length gap), then a final test and multiply. Modulus zero skips to output.
// One request at a time; the next is taken in the cycle after the result is loaded.
// Reset (synchronous, rst high) clears the sequencer and output valid; modulus reads 1.
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 modulus_we,
  input  logic [WIDTH-1:0]     modulus_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // operand_x, operand_y, zero fill
  input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
  // func
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // result, zero fill
  output logic [((WIDTH + 7) / 8) * 8 - 1:0] m_tdata,
  // no_inverse
  output logic                 m_tuser
);

  localparam int DW_OUT = ((WIDTH + 7) / 8) * 8;
  localparam int CW     = $clog2(WIDTH);
  localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_ARITH, S_MUL, S_TEST, S_UP, S_DOWN, S_UPD, S_FIN
  } state_t;

  state_t           state;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] m;
  func_t            func;
  logic [WIDTH-1:0] xs, ys;
  logic [WIDTH-1:0] ax, ay;
  logic [WIDTH-1:0] acc, mb;
  logic [WIDTH-1:0] r0, r1, s, t0, t1;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] res;
  logic             flag;
  logic [WIDTH-1:0] out_res;
  logic             out_flag;
  logic             out_valid;

  logic [WIDTH-1:0] st0_acc, st0_add, st0_sum;
  logic [WIDTH-1:0] st1_sum;
  step_ctl_t        st0_ctl, st1_ctl;
  logic             qbit;
  logic [WIDTH:0]   sub_xy;
  logic [WIDTH:0]   sub_t;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  assign qbit   = (s <= r0);
  assign sub_xy = {1'b0, ax} - {1'b0, ay} + ((ax >= ay) ? '0 : {1'b0, m});
  assign sub_t  = {1'b0, t0} - {1'b0, acc} + ((t0 >= acc) ? '0 : {1'b0, m});

  // Steer the shared step unit
  always_comb begin
    st0_acc = acc;
    st0_add = mb;
    st0_ctl = '{dbl: 1'b1, add: mb[WIDTH-1]};
    case (state)
      S_REDUCE: begin
        st0_acc = ax;
        st0_add = {{(WIDTH-1){1'b0}}, xs[WIDTH-1]};
        st0_ctl = '{dbl: 1'b1, add: 1'b1};
      end
      S_ARITH: begin
        st0_acc = ax;
        st0_add = ay;
        st0_ctl = '{dbl: 1'b0, add: 1'b1};
      end
      S_DOWN: begin
        st0_acc = acc;
        st0_add = t1;
        st0_ctl = '{dbl: 1'b1, add: qbit};
      end
      default: begin
        st0_acc = acc;
        st0_add = ax;
        st0_ctl = '{dbl: 1'b1, add: mb[WIDTH-1]};
      end
    endcase
    st1_ctl = '{dbl: 1'b1, add: 1'b1};
  end

  mau_step #(.W(WIDTH)) u_step0 (
    .acc(st0_acc), .addend(st0_add), .m(m), .ctl(st0_ctl), .sum(st0_sum)
  );

  mau_step #(.W(WIDTH)) u_step1 (
    .acc(ay), .addend({{(WIDTH-1){1'b0}}, ys[WIDTH-1]}), .m(m), .ctl(st1_ctl),
    .sum(st1_sum)
  );

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = DW_OUT'(out_res);
  assign m_tuser  = out_flag;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // drop the output once taken, unless a new result loads this cycle
      if (out_valid && m_tready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            func <= func_t'(s_tuser);
            xs   <= s_tdata[WIDTH-1:0];
            ys   <= s_tdata[2*WIDTH-1:WIDTH];
            m    <= modulus;
            ax   <= '0;
            ay   <= '0;
            cnt  <= CNT_LAST;
            res  <= '0;
            flag <= (func_t'(s_tuser) == FUNC_DIV);
            state <= (modulus == '0) ? S_FIN : S_REDUCE;
          end
        end
        S_REDUCE: begin
          // shift in one operand bit per cycle, reducing as we go
          ax <= st0_sum;
          ay <= st1_sum;
          xs <= {xs[WIDTH-2:0], 1'b0};
          ys <= {ys[WIDTH-2:0], 1'b0};
          cnt <= cnt - CNT_ONE;
          if (cnt == '0) begin
            state <= S_ARITH;
          end
        end
        S_ARITH: begin
          flag <= 1'b0;
          acc  <= '0;
          cnt  <= CNT_LAST;
          case (func)
            FUNC_ADD: begin
              res   <= st0_sum;
              state <= S_FIN;
            end
            FUNC_SUB: begin
              res   <= sub_xy[WIDTH-1:0];
              state <= S_FIN;
            end
            FUNC_MUL: begin
              mb    <= ay;
              state <= S_MUL;
            end
            default: begin
              r0    <= m;
              r1    <= ay;
              t0    <= '0;
              t1    <= (m == WIDTH'(1)) ? '0 : WIDTH'(1);
              state <= S_TEST;
            end
          endcase
        end
        S_MUL: begin
          // one multiplier bit per cycle, most significant first
          acc <= st0_sum;
          mb  <= {mb[WIDTH-2:0], 1'b0};
          cnt <= cnt - CNT_ONE;
          if (cnt == '0) begin
            res   <= st0_sum;
            state <= S_FIN;
          end
        end
        S_TEST: begin
          if (r1 == '0) begin
            if (r0 == WIDTH'(1)) begin
              mb    <= t0;
              acc   <= '0;
              cnt   <= CNT_LAST;
              state <= S_MUL;
            end else begin
              flag  <= 1'b1;
              res   <= '0;
              state <= S_FIN;
            end
          end else begin
            s     <= r1;
            cnt   <= '0;
            state <= S_UP;
          end
        end
        S_UP: begin
          // align the divisor under the remainder
          if ({s, 1'b0} <= {1'b0, r0}) begin
            s   <= {s[WIDTH-2:0], 1'b0};
            cnt <= cnt + CNT_ONE;
          end else begin
            acc   <= '0;
            state <= S_DOWN;
          end
        end
        S_DOWN: begin
          // one quotient bit per cycle; acc gathers q * t1 mod m
          if (qbit) begin
            r0 <= r0 - s;
          end
          acc <= st0_sum;
          s   <= {1'b0, s[WIDTH-1:1]};
          cnt <= cnt - CNT_ONE;
          if (cnt == '0) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          r0 <= r1;
          r1 <= r0;
          t0 <= t1;
          t1 <= sub_t[WIDTH-1:0];
          state <= S_TEST;
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid || m_tready) begin
            out_res   <= res;
            out_flag  <= flag;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/modular_arithmetic_unit_test.sv =====
`timescale 1ns / 1ps

module modular_arithmetic_unit_test;
  import mau_pkg::*;

  localparam int W = 63;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 3000;
  localparam logic [W-1:0] MAXV = {W{1'b1}};

  // Expected results of one modular request
  typedef struct {
    logic [W-1:0] result;
    logic         no_inverse;
  } mod_answer_t;

  // Modular arithmetic predictor
  function automatic logic [W-1:0] mulmod(logic [W-1:0] a, logic [W-1:0] b,
                                          logic [W-1:0] m);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(p % {{W{1'b0}}, m});
  endfunction

  // Extended Euclid; returns 1 when an inverse of a exists modulo m
  function automatic bit invmod(logic [W-1:0] a, logic [W-1:0] m,
                                output logic [W-1:0] inv);
    logic [W-1:0] r0, r1, r2, q, t0, t1, t2, qt;
    r0 = m; r1 = a; t0 = '0;
    t1 = (m == 1) ? '0 : W'(1);
    inv = '0;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - W'(q * r1);
      qt = mulmod(q % m, t1, m);
      t2 = (t0 >= qt) ? t0 - qt : t0 + (m - qt);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 0;
    inv = t0 % m;
    return 1;
  endfunction

  class mau_scoreboard;
    logic [W-1:0] modulus = 1;
    mod_answer_t  pending[$];
    int errors = 0;
    int checked = 0;
    int divides = 0;
    int no_inv_seen = 0;

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // Predict the answer of an accepted request
    function void note(func_t f, logic [W-1:0] xin, logic [W-1:0] yin);
      mod_answer_t a;
      logic [W-1:0] x, y, inv;
      logic [W:0] s;
      a.result = '0;
      a.no_inverse = 1'b0;
      if (f == FUNC_DIV) divides++;
      if (modulus == 0) begin
        a.no_inverse = (f == FUNC_DIV);
      end else begin
        x = xin % modulus;
        y = yin % modulus;
        case (f)
          FUNC_ADD: begin
            s = {1'b0, x} + {1'b0, y};
            if (s >= {1'b0, modulus}) s = s - {1'b0, modulus};
            a.result = s[W-1:0];
          end
          FUNC_SUB: a.result = (x >= y) ? x - y : x + (modulus - y);
          FUNC_MUL: a.result = mulmod(x, y, modulus);
          default: begin
            if (invmod(y, modulus, inv)) a.result = mulmod(x, inv, modulus);
            else a.no_inverse = 1'b1;
          end
        endcase
      end
      pending.push_back(a);
    endfunction

    // Compare a delivered answer with the oldest prediction
    function void check(logic [W-1:0] r, logic f);
      mod_answer_t a;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0h flag %0b", r, f));
        return;
      end
      a = pending.pop_front();
      checked++;
      if (f) no_inv_seen++;
      if (r !== a.result)
        report($sformatf("result %0h, want %0h", r, a.result));
      if (f !== a.no_inverse)
        report($sformatf("no_inverse %0b, want %0b", f, a.no_inverse));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic modulus_we = 0;
  logic [W-1:0] modulus_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic m_tuser;

  mau_scoreboard sb = new();
  int idle_cycles = 0;
  bit stall_req = 0;
  bit stall_busy = 0;

  always #5 clk = ~clk;

  modular_arithmetic_unit #(.WIDTH(W)) dut (
    .clk(clk), .rst(rst),
    .modulus_we(modulus_we), .modulus_wdata(modulus_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Monitor both handshakes and guard against a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note(func_t'(s_tuser), s_tdata[W-1:0], s_tdata[2*W-1:W]);
      if (m_tvalid && m_tready)
        sb.check(m_tdata[W-1:0], m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 120);
  endfunction

  // Receiver: random back-pressure, plus one long hold on request
  initial begin : receiver
    int n;
    @(negedge rst);
    forever begin
      if (stall_req && !stall_busy) begin
        stall_busy = 1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_req = 0;
        stall_busy = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic logic [W-1:0] rand_word();
    return W'({$urandom, $urandom});
  endfunction

  // Drive one request and hold it until accepted
  task automatic send_item(func_t f, logic [W-1:0] x, logic [W-1:0] y);
    int n;
    n = gap_len();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {2'b00, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drain, then write the modulus while the block is idle
  task automatic set_modulus(logic [W-1:0] v);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    modulus_we    <= 1'b1;
    modulus_wdata <= v;
    @(posedge clk);
    modulus_we <= 1'b0;
    sb.modulus = v;
  endtask

  function automatic logic [W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0: return MAXV;
      1: return W'(1);
      2: return W'(2);
      3: return (W'(1) << 61) - 1;
      4: return W'(1) << $urandom_range(1, 62);
      5: return W'($urandom_range(3, 1000));
      6: return W'($urandom_range(3, 60));
      7: return W'({$urandom, 16'h0} >> $urandom_range(0, 30));
      default: return rand_word() | W'(1);
    endcase
  endfunction

  function automatic logic [W-1:0] pick_operand(logic [W-1:0] m);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MAXV;
      2: return m - 1;
      3: return m;
      4, 5: return (m == 0) ? rand_word() : rand_word() % m;
      default: return rand_word();
    endcase
  endfunction

  // Stimulus
  initial begin : stimulus
    logic [W-1:0] m;
    int phase_items;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset modulus of one: everything folds to zero
    send_item(FUNC_DIV, MAXV, MAXV);
    send_item(FUNC_MUL, MAXV, W'(5));

    set_modulus(MAXV);
    send_item(FUNC_ADD, MAXV - 1, MAXV - 1);
    send_item(FUNC_ADD, MAXV, MAXV);
    send_item(FUNC_SUB, '0, MAXV - 1);
    send_item(FUNC_SUB, MAXV - 1, '0);
    send_item(FUNC_MUL, MAXV - 1, MAXV - 1);
    send_item(FUNC_MUL, W'(1) << 62, W'(3));
    send_item(FUNC_DIV, W'(12345), W'(7));
    send_item(FUNC_DIV, W'(1), W'(49));
    send_item(FUNC_DIV, W'(9), '0);

    set_modulus(W'(1));
    send_item(FUNC_ADD, W'(3), W'(4));
    send_item(FUNC_DIV, W'(3), W'(4));

    set_modulus('0);
    send_item(FUNC_ADD, W'(3), W'(4));
    send_item(FUNC_SUB, W'(3), W'(4));
    send_item(FUNC_MUL, W'(3), W'(4));
    send_item(FUNC_DIV, W'(3), W'(4));

    set_modulus(W'(12));
    send_item(FUNC_DIV, W'(5), W'(6));
    send_item(FUNC_DIV, W'(5), W'(7));
    send_item(FUNC_DIV, W'(5), W'(24));
    send_item(FUNC_SUB, W'(100), W'(7));

    set_modulus((W'(1) << 61) - 1);
    send_item(FUNC_DIV, MAXV, (W'(1) << 61) - 2);
    send_item(FUNC_MUL, MAXV, MAXV);

    // Random phases, each under a fresh modulus
    for (int ph = 0; ph < 14; ph++) begin
      m = (ph == 0) ? MAXV : (ph == 1) ? W'(1) : pick_modulus();
      set_modulus(m);
      if (ph == 3) stall_req = 1;
      phase_items = 128;
      for (int i = 0; i < phase_items; i++)
        send_item(func_t'($urandom_range(0, 3)), pick_operand(m), pick_operand(m));
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d results (%0d divides, %0d without inverse) over many moduli,",
             sb.checked, sb.divides, sb.no_inv_seen);
    $display("including extreme, zero and one moduli and a long output hold");
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
